[design/sgm_pkg.sv]
// Shared types and constants for the stereo gain / mute / level meter core.
// No dependencies; every other design file imports this package.
package sgm_pkg;

  localparam int SEGMENTS   = 11;   // meter segments per channel
  localparam int SAMPLE_W   = 16;
  localparam int GAIN_W     = 10;
  localparam int HOLD_W     = 15;
  localparam int SEG_OUT_W  = 11;   // segment bits carried in a result beat
  localparam int PROD_W     = SAMPLE_W + GAIN_W + 1;
  localparam int SHIFT_W    = PROD_W - 8;
  localparam int CMP_W      = 17 + $clog2(SEGMENTS);
  localparam int SEG_PAD_W  = (SEGMENTS > SEG_OUT_W) ? SEGMENTS : SEG_OUT_W;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 15;

  localparam logic [CFG_IDX_W-1:0] REG_GAIN_SCALE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_SHORT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_LONG  = 2'd2;

  localparam logic [GAIN_W-1:0] GAIN_RESET       = 10'd256;
  localparam logic [HOLD_W-1:0] HOLD_SHORT_RESET = 15'd5000;
  localparam logic [HOLD_W-1:0] HOLD_LONG_RESET  = 15'd20000;

  // Toggle input Schmitt levels, Q4.11
  localparam logic signed [SAMPLE_W-1:0] TOGGLE_HI = 16'sd2048;
  localparam logic signed [SAMPLE_W-1:0] TOGGLE_LO = 16'sd0;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left_sample;
    logic signed [SAMPLE_W-1:0] right_sample;
    logic                       button_level;
    logic signed [SAMPLE_W-1:0] toggle_voltage;
  } in_beat_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left_thru;
    logic signed [SAMPLE_W-1:0] right_thru;
    logic signed [SAMPLE_W-1:0] left_main;
    logic signed [SAMPLE_W-1:0] right_main;
    logic                       on_lamp;
    logic [SEG_OUT_W-1:0]       left_segments;
    logic [SEG_OUT_W-1:0]       right_segments;
  } out_beat_t;

  // Pipeline advance strobes handed to each channel lane
  typedef struct packed {
    logic s1_en;
    logic s2_en;
  } lane_ctl_t;

endpackage

[design/sgm_on_ctrl.sv]
// On/mute flag control: button edge detect and toggle-input Schmitt trigger.
// Depends on sgm_pkg.
module sgm_on_ctrl (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 accept,
  input  logic                                 button_level,
  input  logic signed [sgm_pkg::SAMPLE_W-1:0]  toggle_voltage,
  output logic                                 on_nxt
);
  import sgm_pkg::*;

  logic btn_hi_r, btn_hi_nxt;
  logic tog_hi_r, tog_hi_nxt;
  logic on_r;
  logic edge_hit;

  always_comb begin
    edge_hit   = 1'b0;
    btn_hi_nxt = btn_hi_r;
    tog_hi_nxt = tog_hi_r;
    if (btn_hi_r) begin
      if (!button_level) btn_hi_nxt = 1'b0;
    end else if (button_level) begin
      btn_hi_nxt = 1'b1;
      edge_hit   = 1'b1;
    end
    if (tog_hi_r) begin
      if (toggle_voltage <= TOGGLE_LO) tog_hi_nxt = 1'b0;
    end else if (toggle_voltage >= TOGGLE_HI) begin
      tog_hi_nxt = 1'b1;
      edge_hit   = 1'b1;
    end
    // both edges in one beat still flip once
    on_nxt = edge_hit ? ~on_r : on_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      btn_hi_r <= 1'b0;
      tog_hi_r <= 1'b0;
      on_r     <= 1'b1;
    end else if (accept) begin
      btn_hi_r <= btn_hi_nxt;
      tog_hi_r <= tog_hi_nxt;
      on_r     <= on_nxt;
    end
  end

endmodule

[design/sgm_lane.sv]
// One channel lane: gain multiply (stage 1), saturate and segment meter (stage 2).
// Depends on sgm_pkg.
module sgm_lane (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  sgm_pkg::lane_ctl_t                   ctl,
  input  logic signed [sgm_pkg::SAMPLE_W-1:0]  sample,
  input  logic                                 on_flag,
  input  logic [sgm_pkg::GAIN_W-1:0]           gain_scale,
  input  logic [sgm_pkg::HOLD_W-1:0]           hold_short,
  input  logic [sgm_pkg::HOLD_W-1:0]           hold_long,
  output logic signed [sgm_pkg::SAMPLE_W-1:0]  main_r,
  output logic [sgm_pkg::SEG_OUT_W-1:0]        seg_r
);
  import sgm_pkg::*;

  logic signed [PROD_W-1:0]  prod_r, prod_nxt;
  logic signed [SHIFT_W-1:0] shifted;
  logic signed [SAMPLE_W-1:0] main_nxt;
  logic signed [CMP_W-1:0]   main_ext;
  logic [HOLD_W-1:0]         cnt_r   [SEGMENTS];
  logic [HOLD_W-1:0]         cnt_nxt [SEGMENTS];
  logic [HOLD_W-1:0]         cnt_ld  [SEGMENTS];
  logic [SEGMENTS-1:0]       lit;
  logic [SEG_PAD_W-1:0]      lit_pad;

  // muted lanes carry a zero product
  assign prod_nxt = on_flag ? PROD_W'(sample) * PROD_W'($signed({1'b0, gain_scale})) : '0;

  always_ff @(posedge clk) begin
    if (ctl.s1_en) prod_r <= prod_nxt;
  end

  always_comb begin
    // arithmetic shift is floor division by 256
    shifted = SHIFT_W'(prod_r >>> 8);
    if (shifted > SHIFT_W'(32767))
      main_nxt = 16'sh7FFF;
    else if (shifted < -SHIFT_W'(32768))
      main_nxt = 16'sh8000;
    else
      main_nxt = shifted[SAMPLE_W-1:0];
    main_ext = CMP_W'(main_nxt);
  end

  always_comb begin
    for (int i = 0; i < SEGMENTS; i++) begin
      if (main_ext > $signed(CMP_W'(i * 2048)))
        cnt_ld[i] = (i == SEGMENTS - 1) ? hold_long : hold_short;
      else
        cnt_ld[i] = cnt_r[i];
      lit[i]     = |cnt_ld[i];
      cnt_nxt[i] = lit[i] ? cnt_ld[i] - 1'b1 : '0;
    end
    lit_pad = SEG_PAD_W'(lit);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SEGMENTS; i++) cnt_r[i] <= '0;
    end else if (ctl.s2_en) begin
      for (int i = 0; i < SEGMENTS; i++) cnt_r[i] <= cnt_nxt[i];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.s2_en) begin
      main_r <= main_nxt;
      seg_r  <= lit_pad[SEG_OUT_W-1:0];
    end
  end

endmodule

[design/stereo_gain_mute_level_meter_core.sv]
// Top level: config registers, two-stage valid/ready pipeline, two channel lanes
// merged into one result beat. Depends on sgm_pkg, sgm_on_ctrl, sgm_lane.

// One stereo pair in, one result beat out, one beat per clock sustained while
// out_ready stays high: stage 1 applies the mute edge logic and the gain
// multiply, stage 2 saturates and runs the 11-segment hold meters, whose
// counters carry state from beat to beat. The left and right channels run in
// two identical lanes side by side and their results are merged into one
// beat. A new input beat is taken while a finished result waits for
// out_ready only if stage 1 is empty. Config writes (cfg_ready is always
// high) should be made with the pipeline empty; index 3 is ignored.
module stereo_gain_mute_level_meter_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  sgm_pkg::in_beat_t                 in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output sgm_pkg::out_beat_t                out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [sgm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [sgm_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import sgm_pkg::*;

  logic [GAIN_W-1:0] gain_r;
  logic [HOLD_W-1:0] hold_short_r;
  logic [HOLD_W-1:0] hold_long_r;

  logic s1_v_r, out_v_r;
  logic accept, adv2;
  logic on_nxt;
  lane_ctl_t ctl;

  logic signed [SAMPLE_W-1:0] s1_left_r, s1_right_r;
  logic s1_on_r;
  logic signed [SAMPLE_W-1:0] o_left_r, o_right_r;
  logic o_on_r;
  logic signed [SAMPLE_W-1:0] l_main, r_main;
  logic [SEG_OUT_W-1:0] l_seg, r_seg;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r       <= GAIN_RESET;
      hold_short_r <= HOLD_SHORT_RESET;
      hold_long_r  <= HOLD_LONG_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_GAIN_SCALE: gain_r       <= cfg_data[GAIN_W-1:0];
        REG_HOLD_SHORT: hold_short_r <= cfg_data[HOLD_W-1:0];
        REG_HOLD_LONG:  hold_long_r  <= cfg_data[HOLD_W-1:0];
        default: ;
      endcase
    end
  end

  assign adv2     = s1_v_r && (!out_v_r || out_ready);
  assign in_ready = !s1_v_r || adv2;
  assign accept   = in_valid && in_ready;
  assign ctl      = '{s1_en: accept, s2_en: adv2};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (accept)    s1_v_r <= 1'b1;
      else if (adv2) s1_v_r <= 1'b0;
      if (adv2)           out_v_r <= 1'b1;
      else if (out_ready) out_v_r <= 1'b0;
    end
  end

  sgm_on_ctrl u_on (
    .clk            (clk),
    .rst_n          (rst_n),
    .accept         (accept),
    .button_level   (in_data.button_level),
    .toggle_voltage (in_data.toggle_voltage),
    .on_nxt         (on_nxt)
  );

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_left_r  <= in_data.left_sample;
      s1_right_r <= in_data.right_sample;
      s1_on_r    <= on_nxt;
    end
    if (adv2) begin
      o_left_r  <= s1_left_r;
      o_right_r <= s1_right_r;
      o_on_r    <= s1_on_r;
    end
  end

  sgm_lane u_left (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .sample     (in_data.left_sample),
    .on_flag    (on_nxt),
    .gain_scale (gain_r),
    .hold_short (hold_short_r),
    .hold_long  (hold_long_r),
    .main_r     (l_main),
    .seg_r      (l_seg)
  );

  sgm_lane u_right (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .sample     (in_data.right_sample),
    .on_flag    (on_nxt),
    .gain_scale (gain_r),
    .hold_short (hold_short_r),
    .hold_long  (hold_long_r),
    .main_r     (r_main),
    .seg_r      (r_seg)
  );

  // merge the two lanes into one result beat
  assign out_valid = out_v_r;
  always_comb begin
    out_data.left_thru      = o_left_r;
    out_data.right_thru     = o_right_r;
    out_data.left_main      = l_main;
    out_data.right_main     = r_main;
    out_data.on_lamp        = o_on_r;
    out_data.left_segments  = l_seg;
    out_data.right_segments = r_seg;
  end

endmodule

[tb/tb.sv]
// Self-checking bench for stereo_gain_mute_level_meter_core: directed and random beats
// against a cycle-free tracker of mute state, gain and segment hold counters.
// Depends on sgm_pkg and the core RTL only.
module tb;
  import sgm_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int STALL_LIMIT     = 2000;
  localparam int HOLD_OFF_CYCLES = 80;
  localparam int RAND_PHASES     = 6;
  localparam int PHASE_BEATS     = 210;

  class stage_tracker;
    logic [GAIN_W-1:0] gain;
    logic [HOLD_W-1:0] hold_short;
    logic [HOLD_W-1:0] hold_long;
    bit                on_flag;
    bit                btn_high;
    bit                tog_high;
    logic [HOLD_W-1:0] hold_cnt [2][SEGMENTS];
    out_beat_t         beats_due[$];
    int                errors;

    function new();
      gain       = GAIN_RESET;
      hold_short = HOLD_SHORT_RESET;
      hold_long  = HOLD_LONG_RESET;
      on_flag    = 1'b1;
      btn_high   = 1'b0;
      tog_high   = 1'b0;
      foreach (hold_cnt[c, i]) hold_cnt[c][i] = '0;
      errors     = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
      case (idx)
        REG_GAIN_SCALE: gain       = d[GAIN_W-1:0];
        REG_HOLD_SHORT: hold_short = d[HOLD_W-1:0];
        REG_HOLD_LONG:  hold_long  = d[HOLD_W-1:0];
        default: ;
      endcase
    endfunction

    // floor(s * gain / 256), zero while muted, saturated
    function logic signed [SAMPLE_W-1:0] scaled(logic signed [SAMPLE_W-1:0] s);
      int q;
      if (!on_flag) return '0;
      q = (int'(s) * int'(gain)) >>> 8;
      if (q > 32767) q = 32767;
      else if (q < -32768) q = -32768;
      return q[SAMPLE_W-1:0];
    endfunction

    function logic [SEG_OUT_W-1:0] meter(int ch, logic signed [SAMPLE_W-1:0] m);
      logic [SEG_OUT_W-1:0] lit;
      lit = '0;
      for (int i = 0; i < SEGMENTS; i++)
        if (int'(m) > i * 2048) hold_cnt[ch][i] = (i == SEGMENTS - 1) ? hold_long : hold_short;
      for (int i = 0; i < SEGMENTS; i++) begin
        if (hold_cnt[ch][i] != '0) begin
          hold_cnt[ch][i] = hold_cnt[ch][i] - 1'b1;
          if (i < SEG_OUT_W) lit[i] = 1'b1;
        end
      end
      return lit;
    endfunction

    function void note_input(in_beat_t b);
      bit        flip;
      out_beat_t e;
      flip = 1'b0;
      if (btn_high) begin
        if (!b.button_level) btn_high = 1'b0;
      end else if (b.button_level) begin
        btn_high = 1'b1;
        flip = 1'b1;
      end
      // Schmitt trigger on the toggle input
      if (tog_high) begin
        if (b.toggle_voltage <= TOGGLE_LO) tog_high = 1'b0;
      end else if (b.toggle_voltage >= TOGGLE_HI) begin
        tog_high = 1'b1;
        flip = 1'b1;
      end
      if (flip) on_flag = !on_flag;
      e.left_thru      = b.left_sample;
      e.right_thru     = b.right_sample;
      e.left_main      = scaled(b.left_sample);
      e.right_main     = scaled(b.right_sample);
      e.on_lamp        = on_flag;
      e.left_segments  = meter(0, e.left_main);
      e.right_segments = meter(1, e.right_main);
      beats_due.push_back(e);
    endfunction

    function void check_result(out_beat_t a);
      out_beat_t e;
      string     bad;
      if (beats_due.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result beat %h", a);
        return;
      end
      e = beats_due.pop_front();
      bad = "";
      if (a.left_thru !== e.left_thru) bad = {bad, " left_thru"};
      if (a.right_thru !== e.right_thru) bad = {bad, " right_thru"};
      if (a.left_main !== e.left_main) bad = {bad, " left_main"};
      if (a.right_main !== e.right_main) bad = {bad, " right_main"};
      if (a.on_lamp !== e.on_lamp) bad = {bad, " on_lamp"};
      if (a.left_segments !== e.left_segments) bad = {bad, " left_segments"};
      if (a.right_segments !== e.right_segments) bad = {bad, " right_segments"};
      if (bad != "") begin
        errors++;
        if (errors <= 10) begin
          $display("mismatch in%s", bad);
          $display("  exp thru %0d %0d main %0d %0d lamp %0b seg %03h %03h",
                   e.left_thru, e.right_thru, e.left_main, e.right_main, e.on_lamp,
                   e.left_segments, e.right_segments);
          $display("  got thru %0d %0d main %0d %0d lamp %0b seg %03h %03h",
                   a.left_thru, a.right_thru, a.left_main, a.right_main, a.on_lamp,
                   a.left_segments, a.right_segments);
        end
      end
    endfunction

    function int pending();
      return beats_due.size();
    endfunction
  endclass

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  in_beat_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_beat_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  stage_tracker trk = new();
  int in_idle_pct   = 6;
  int out_idle_pct  = 6;
  int hold_requests = 0;
  int holds_served  = 0;
  int hold_left     = 0;
  int stall_cycles  = 0;
  bit btn_level     = 1'b0;

  always #5 clk = ~clk;

  stereo_gain_mute_level_meter_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) trk.note_input(in_data);
      if (out_valid && out_ready) trk.check_result(out_data);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("tb: errors");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Result side: random stalls, plus a long hold-off whenever one is requested
  always @(negedge clk) begin
    if (hold_requests != holds_served) begin
      holds_served++;
      hold_left = HOLD_OFF_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= out_idle_pct);
    end
  end

  task automatic send_beat(in_beat_t b);
    if ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (trk.pending() != 0) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
    trk.write_reg(idx, d);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic configure(logic [GAIN_W-1:0] g, logic [HOLD_W-1:0] hs, logic [HOLD_W-1:0] hl);
    drain();
    write_reg(REG_UNUSED, 15'($urandom));
    // upper data bits are junk for the gain register
    write_reg(REG_GAIN_SCALE, {5'($urandom), g});
    write_reg(REG_HOLD_SHORT, hs);
    write_reg(REG_HOLD_LONG, hl);
  endtask

  function automatic in_beat_t pair_beat(int l, int r, bit btn, int tog);
    in_beat_t b;
    b.left_sample    = 16'(l);
    b.right_sample   = 16'(r);
    b.button_level   = btn;
    b.toggle_voltage = 16'(tog);
    return b;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(9))
      0, 1:    return 16'($urandom);
      2:       return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
      3:       return 16'(int'($urandom_range(64)) - 32);
      default: return 16'(int'($urandom_range(46000)) - 23000);
    endcase
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] rand_toggle();
    case ($urandom_range(9))
      0, 1: return 16'($urandom);
      2: begin
        case ($urandom_range(4))
          0:       return 16'sd0;
          1:       return 16'sd1;
          2:       return 16'sd2047;
          3:       return 16'sd2048;
          default: return -16'sd1;
        endcase
      end
      default: return 16'(int'($urandom_range(2500)) - 200);
    endcase
  endfunction

  function automatic logic [GAIN_W-1:0] pick_gain();
    case ($urandom_range(5))
      0:       return 10'd0;
      1:       return 10'd1023;
      2:       return 10'd512;
      3:       return 10'd256;
      default: return 10'($urandom_range(1023));
    endcase
  endfunction

  function automatic logic [HOLD_W-1:0] pick_hold();
    case ($urandom_range(9))
      0:       return 15'd0;
      1:       return 15'd1;
      2:       return 15'd32767;
      default: return 15'($urandom_range(40, 2));
    endcase
  endfunction

  initial begin
    in_beat_t b;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset settings: extremes, button and toggle edges, meter thresholds
    send_beat(pair_beat(0, 0, 0, 0));
    send_beat(pair_beat(32767, -32768, 0, 0));
    send_beat(pair_beat(-32768, 32767, 0, 0));
    send_beat(pair_beat(1000, -1000, 1, 0));
    send_beat(pair_beat(1000, -1000, 1, 0));
    send_beat(pair_beat(1000, -1000, 0, 0));
    send_beat(pair_beat(3000, 3000, 0, 2047));
    send_beat(pair_beat(3000, 3000, 0, 2048));
    send_beat(pair_beat(3000, 3000, 0, 1));
    send_beat(pair_beat(3000, 3000, 0, 0));
    send_beat(pair_beat(5000, 5000, 1, 2048));   // both edges at once
    send_beat(pair_beat(5000, 5000, 0, -32768));
    send_beat(pair_beat(5000, 5000, 0, 32767));
    send_beat(pair_beat(2048, 2049, 0, 0));
    send_beat(pair_beat(1, -1, 0, 0));

    // gain 1023 saturates full-scale samples; a zero short hold darkens each short-hold segment a sample crosses
    configure(10'd1023, 15'd0, 15'd1);
    send_beat(pair_beat(32767, -32768, 0, 0));
    send_beat(pair_beat(8, -9, 0, 0));
    send_beat(pair_beat(21000, 300, 0, 0));

    configure(10'd0, 15'd32767, 15'd32767);
    send_beat(pair_beat(32767, -32768, 0, 0));
    send_beat(pair_beat(1, -1, 0, 0));
    send_beat(pair_beat(12345, -5, 0, 0));

    configure(10'd512, 15'd3, 15'd0);
    send_beat(pair_beat(16383, -16384, 0, 0));
    send_beat(pair_beat(16384, 100, 0, 0));
    send_beat(pair_beat(-1, 1, 0, 0));

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      configure(pick_gain(), pick_hold(), pick_hold());
      in_idle_pct  = (ph == 2) ? 0 : 6;
      out_idle_pct = (ph == 2) ? 0 : 6;
      for (int n = 0; n < PHASE_BEATS; n++) begin
        if (ph == 1 && n == 50) hold_requests++;
        if (ph == 1 && n == 150) drain();
        if ($urandom_range(99) < 8) btn_level = ~btn_level;
        b.left_sample    = rand_sample();
        b.right_sample   = rand_sample();
        b.button_level   = btn_level;
        b.toggle_voltage = rand_toggle();
        send_beat(b);
      end
    end

    drain();
    repeat (8) @(negedge clk);
    if (trk.errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
